>>> hw/rtl/sc1_pkg.sv
// Shared types, scancode constants and character tables for the Set 1 decoder.
package sc1_pkg;

  localparam int unsigned KeySlots = 128;
  localparam int unsigned KeyW     = $clog2(KeySlots);
  localparam int unsigned AddrW    = KeyW + 1;

  localparam logic [7:0]      PrefixByte = 8'hE0;
  localparam logic [KeyW-1:0] ScF1       = 7'h3B;
  localparam logic [KeyW-1:0] ScLShift   = 7'h2A;
  localparam logic [KeyW-1:0] ScRShift   = 7'h36;
  localparam logic [KeyW-1:0] ScCtrl     = 7'h1D;
  localparam logic [KeyW-1:0] ScAlt      = 7'h38;
  localparam logic [KeyW-1:0] ScCaps     = 7'h3A;

  typedef enum logic [1:0] {
    TblBase  = 2'd0,
    TblShift = 2'd1,
    TblAltGr = 2'd2
  } table_e;

  typedef struct packed {
    logic       command;
    logic [7:0] scan_byte;
    logic       query_extended;
    logic [6:0] query_key;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic       snapshot_event;
    logic       key_is_down;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
    logic       altgr_down;
    logic       caps_on;
  } out_t;

  // Control carried from the decode stage to the lookup stage.
  typedef struct packed {
    logic       lookup;
    table_e     tbl;
    logic [6:0] key;
    logic       snap;
    logic       query;
    logic [AddrW-1:0] qaddr;
  } op_t;

  function automatic logic [7:0] char_rom(input table_e tbl, input logic [6:0] key);
    logic [7:0] b, s, a;
    b = 8'd0;
    s = 8'd0;
    a = 8'd0;
    case (key)
      7'd1:  begin b = 8'd27; s = 8'd27; a = 8'd27; end
      7'd2:  begin b = "1"; s = "!"; a = "|"; end
      7'd3:  begin b = "2"; s = "\""; a = "@"; end
      7'd4:  begin b = "3"; s = "#"; a = 8'd249; end
      7'd5:  begin b = "4"; s = "$"; a = "~"; end
      7'd6:  begin b = "5"; s = "%"; a = 8'd128; end
      7'd7:  begin b = "6"; s = "&"; a = 8'd172; end
      7'd8:  begin b = "7"; s = "/"; a = "7"; end
      7'd9:  begin b = "8"; s = "("; a = "8"; end
      7'd10: begin b = "9"; s = ")"; a = "9"; end
      7'd11: begin b = "0"; s = "="; a = "0"; end
      7'd12: begin b = "'"; s = "?"; a = "\\"; end
      7'd13: begin b = 8'd191; s = 8'd161; a = 8'd191; end
      7'd14: begin b = 8'd8; s = 8'd8; a = 8'd8; end
      7'd15: begin b = 8'd9; s = 8'd9; a = 8'd9; end
      7'd16: begin b = "q"; s = "Q"; a = "@"; end
      7'd17: begin b = "w"; s = "W"; a = "w"; end
      7'd18: begin b = "e"; s = "E"; a = 8'd128; end
      7'd19: begin b = "r"; s = "R"; a = "r"; end
      7'd20: begin b = "t"; s = "T"; a = "t"; end
      7'd21: begin b = "y"; s = "Y"; a = "y"; end
      7'd22: begin b = "u"; s = "U"; a = "u"; end
      7'd23: begin b = "i"; s = "I"; a = "i"; end
      7'd24: begin b = "o"; s = "O"; a = "o"; end
      7'd25: begin b = "p"; s = "P"; a = "p"; end
      7'd27: begin b = "+"; s = "*"; a = "~"; end
      7'd28: begin b = 8'd10; s = 8'd10; a = 8'd10; end
      7'd30: begin b = "a"; s = "A"; a = "a"; end
      7'd31: begin b = "s"; s = "S"; a = "s"; end
      7'd32: begin b = "d"; s = "D"; a = "d"; end
      7'd33: begin b = "f"; s = "F"; a = "f"; end
      7'd34: begin b = "g"; s = "G"; a = "g"; end
      7'd35: begin b = "h"; s = "H"; a = "h"; end
      7'd36: begin b = "j"; s = "J"; a = "j"; end
      7'd37: begin b = "k"; s = "K"; a = "k"; end
      7'd38: begin b = "l"; s = "L"; a = "l"; end
      7'd39: begin b = 8'd241; s = 8'd209; a = 8'd241; end
      7'd40: begin b = "{"; s = "["; a = "^"; end
      7'd41: begin b = "|"; s = 8'd176; a = 8'd0; end
      7'd43: begin b = "}"; s = "]"; a = 8'd0; end
      7'd44: begin b = "z"; s = "Z"; a = "z"; end
      7'd45: begin b = "x"; s = "X"; a = "x"; end
      7'd46: begin b = "c"; s = "C"; a = "c"; end
      7'd47: begin b = "v"; s = "V"; a = "v"; end
      7'd48: begin b = "b"; s = "B"; a = "b"; end
      7'd49: begin b = "n"; s = "N"; a = "n"; end
      7'd50: begin b = "m"; s = "M"; a = "m"; end
      7'd51: begin b = ","; s = ";"; a = ","; end
      7'd52: begin b = "."; s = ":"; a = 8'd249; end
      7'd53: begin b = "-"; s = "_"; a = "_"; end
      7'd55: begin b = "*"; s = "*"; a = "*"; end
      7'd57: begin b = " "; s = " "; a = " "; end
      7'd71: begin b = "7"; s = "7"; a = "7"; end
      7'd72: begin b = "8"; s = "8"; a = "8"; end
      7'd73: begin b = "9"; s = "9"; a = "9"; end
      7'd74: begin b = "-"; s = "-"; a = "-"; end
      7'd75: begin b = "4"; s = "4"; a = "4"; end
      7'd76: begin b = "5"; s = "5"; a = "5"; end
      7'd77: begin b = "6"; s = "6"; a = "6"; end
      7'd78: begin b = "+"; s = "+"; a = "+"; end
      7'd79: begin b = "1"; s = "1"; a = "1"; end
      7'd80: begin b = "2"; s = "2"; a = "2"; end
      7'd81: begin b = "3"; s = "3"; a = "3"; end
      7'd82: begin b = "0"; s = "0"; a = "0"; end
      7'd83: begin b = "."; s = "."; a = "."; end
      7'd86: begin b = "<"; s = ">"; a = "|"; end
      default: begin b = 8'd0; s = 8'd0; a = 8'd0; end
    endcase
    case (tbl)
      TblShift: char_rom = s;
      TblAltGr: char_rom = a;
      default:  char_rom = b;
    endcase
  endfunction

endpackage

>>> hw/rtl/scancode_set1_to_ascii_decoder_top.sv
// Top level of the Set 1 scancode to character decoder.
//
// Input beats carry either a scancode byte (command 0) or a key query
// (command 1); each input beat yields exactly one output beat.
// A beat is decoded in the cycle it is accepted: the bitmap memory is
// written then and the modifier levels, prefix count and caps flag are
// kept in flip-flops alongside. A query reads the bitmap memory, whose
// registered data arrives in the cycle after acceptance, when the
// character table is also looked up and the result is loaded into the
// output register. Output valid rises once that register is loaded, so
// a result passes the lookup stage and the output register. A new beat is
// accepted every cycle while the output stage can move: a write in one
// cycle is seen by a query in the next, since the memory write lands
// before the registered read of the following cycle.
// When the receiver stalls, the lookup stage and output register hold and
// input ready drops once both are full.
// Reset clears all keys to released, the prefix count and the caps flag;
// no clearing pass is needed, valid bits cover the bitmap.
module scancode_set1_to_ascii_decoder_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sc1_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output sc1_pkg::out_t out_data_o
);
  // Modifier mirror bits: lshift, rshift, ctrl normal, ctrl ext, alt, altgr.
  logic       lsh_q, rsh_q, ctl0_q, ctl1_q, alt_q, agr_q;
  logic       lsh_d, rsh_d, ctl0_d, ctl1_d, alt_d, agr_d;
  logic [1:0] pfx_q, pfx_d;
  logic       caps_q, caps_d;

  logic          s1_vld_q;
  sc1_pkg::op_t  s1_op_q, op_d;
  logic [4:0]    s1_lvl_q;  // shift, ctrl, alt, altgr, caps
  logic          s1_go;
  logic          acc;

  logic                      we;
  logic [sc1_pkg::AddrW-1:0] waddr;
  logic                      wdata;
  logic                      rdata;

  sc1_pkg::out_t out_q, out_d;
  logic          out_vld_q;

  logic [6:0] key;
  logic       make;
  logic       shift_now;

  assign s1_go      = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || s1_go;
  assign acc        = in_valid_i && in_ready_o;

  assign key  = in_data_i.scan_byte[6:0];
  assign make = !in_data_i.scan_byte[7];

  always_comb begin
    lsh_d  = lsh_q;
    rsh_d  = rsh_q;
    ctl0_d = ctl0_q;
    ctl1_d = ctl1_q;
    alt_d  = alt_q;
    agr_d  = agr_q;
    pfx_d  = pfx_q;
    caps_d = caps_q;
    we     = 1'b0;
    waddr  = {1'b0, key};
    wdata  = make;
    op_d   = '0;
    op_d.tbl   = sc1_pkg::TblBase;
    op_d.key   = key;
    op_d.qaddr = {in_data_i.query_extended, in_data_i.query_key};
    shift_now  = lsh_q | rsh_q;
    if (in_data_i.command) begin
      op_d.query = 1'b1;
    end else if (in_data_i.scan_byte == sc1_pkg::PrefixByte) begin
      if (pfx_q != 2'd3) begin
        pfx_d = pfx_q + 2'd1;
      end
    end else if (pfx_q != 2'd0) begin
      we    = 1'b1;
      waddr = {1'b1, key};
      pfx_d = pfx_q - 2'd1;
      if (key == sc1_pkg::ScCtrl) ctl1_d = make;
      if (key == sc1_pkg::ScAlt)  agr_d  = make;
    end else begin
      we = 1'b1;
      if (key == sc1_pkg::ScLShift) lsh_d  = make;
      if (key == sc1_pkg::ScRShift) rsh_d  = make;
      if (key == sc1_pkg::ScCtrl)   ctl0_d = make;
      if (key == sc1_pkg::ScAlt)    alt_d  = make;
      if (make) begin
        if (key == sc1_pkg::ScF1) begin
          op_d.snap = 1'b1;
        end else begin
          if (key == sc1_pkg::ScCaps) caps_d = !caps_q;
          op_d.lookup = 1'b1;
          if (agr_q) begin
            op_d.tbl = sc1_pkg::TblAltGr;
          end else if (shift_now ^ caps_d) begin
            op_d.tbl = sc1_pkg::TblShift;
          end
        end
      end
    end
    if (!acc) begin
      we     = 1'b0;
      pfx_d  = pfx_q;
      caps_d = caps_q;
      lsh_d  = lsh_q;
      rsh_d  = rsh_q;
      ctl0_d = ctl0_q;
      ctl1_d = ctl1_q;
      alt_d  = alt_q;
      agr_d  = agr_q;
    end
  end

  sc1_keymem u_keymem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (acc),
    .raddr_i (op_d.qaddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsh_q    <= 1'b0;
      rsh_q    <= 1'b0;
      ctl0_q   <= 1'b0;
      ctl1_q   <= 1'b0;
      alt_q    <= 1'b0;
      agr_q    <= 1'b0;
      pfx_q    <= 2'd0;
      caps_q   <= 1'b0;
      s1_vld_q <= 1'b0;
    end else begin
      lsh_q  <= lsh_d;
      rsh_q  <= rsh_d;
      ctl0_q <= ctl0_d;
      ctl1_q <= ctl1_d;
      alt_q  <= alt_d;
      agr_q  <= agr_d;
      pfx_q  <= pfx_d;
      caps_q <= caps_d;
      if (in_ready_o) begin
        s1_vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_op_q  <= op_d;
      s1_lvl_q <= {lsh_d | rsh_d, ctl0_d | ctl1_d, alt_d, agr_d, caps_d};
    end
  end

  always_comb begin
    out_d                = '0;
    out_d.char_code      = s1_op_q.lookup ? sc1_pkg::char_rom(s1_op_q.tbl, s1_op_q.key)
                                          : 8'd0;
    out_d.char_valid     = out_d.char_code != 8'd0;
    out_d.snapshot_event = s1_op_q.snap;
    out_d.key_is_down    = s1_op_q.query & rdata;
    out_d.shift_down     = s1_lvl_q[4];
    out_d.ctrl_down      = s1_lvl_q[3];
    out_d.alt_down       = s1_lvl_q[2];
    out_d.altgr_down     = s1_lvl_q[1];
    out_d.caps_on        = s1_lvl_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
endmodule

>>> hw/rtl/sc1_keymem.sv
// Key bitmap memory with valid bits: one write port, one registered read port.
module sc1_keymem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [sc1_pkg::AddrW-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic                     re_i,
  input  logic [sc1_pkg::AddrW-1:0] raddr_i,
  output logic                     rdata_o
);
  localparam int unsigned Depth = 2 * sc1_pkg::KeySlots;

  logic             mem_q [Depth];
  logic [Depth-1:0] vld_q;
  logic             rd_q;
  logic             rv_q;

  // Entries never written read as released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
      rd_q <= 1'b0;
    end else if (re_i) begin
      rv_q <= vld_q[raddr_i];
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rv_q & rd_q;
endmodule
